// ----- rtl/gcov_pkg.sv -----
// Shared constants, types and helper functions for the Gaussian covariance block.
// Used by every module and interface of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gcov_pkg;

    // Field and configuration widths.
    localparam int LAG_W     = 16;
    localparam int CFG_W     = 16;
    localparam int COV_W     = 17;
    localparam int CFG_IDX_W = 2;

    // Internal datapath widths.
    localparam int R2_W  = 32;     // squared range
    localparam int H2_W  = 32;     // squared lag
    localparam int H3_W  = 34;     // three times squared lag
    localparam int Q_W   = 21;     // quotient t in Q16, up to 16.0 inclusive
    localparam int NUM_W = 51;     // rounded dividend (3*h^2 << 16) + r^2/2
    localparam int E_W   = 31;     // exponential in Q30, up to 1.0 inclusive
    localparam int F_W   = 17;     // factor in Q16, up to 1.0 inclusive
    localparam int SQ_N  = 8;      // number of squarings

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SILL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUGGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] SILL_RST   = 16'd256;
    localparam logic [CFG_W-1:0] NUGGET_RST = 16'd0;
    localparam logic [CFG_W-1:0] RANGE_RST  = 16'd256;

    localparam logic [COV_W-1:0] COV_MAX = 17'h1FFFF;
    localparam logic [F_W-1:0]   F_ONE   = 17'h10000;

    // Reciprocal multipliers for the Taylor series divisions.
    localparam logic [17:0] DIV3_MUL  = 18'd174763;
    localparam logic [7:0]  DIV15_MUL = 8'd137;

    // Sideband that travels with every pipeline stage.
    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
    } t_side;

    // One result item.
    typedef struct packed {
        logic [COV_W-1:0] covariance;
        logic             last_out;
    } t_res;

    // Exact floor(x / 3) for any 17-bit x.
    function automatic logic [15:0] div3(input logic [16:0] x);
        logic [34:0] p;
        p = {18'b0, x} * {17'b0, DIV3_MUL};
        return p[34:19];
    endfunction

    // Exact floor(x / 15) for any 7-bit x.
    function automatic logic [3:0] div15(input logic [6:0] x);
        logic [14:0] p;
        p = {8'b0, x} * {7'b0, DIV15_MUL};
        return p[14:11];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gcov_if.sv -----
// Valid/ready channel interfaces for the Gaussian covariance block: lag items in,
// covariance items out and configuration writes. Depends on gcov_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gcov_in_if;
    import gcov_pkg::*;
    logic             valid;
    logic             ready;
    logic [LAG_W-1:0] lag_distance;
    logic             last_in;
    modport source (output valid, output lag_distance, output last_in, input ready);
    modport sink   (input valid, input lag_distance, input last_in, output ready);
endinterface

interface gcov_out_if;
    import gcov_pkg::*;
    logic             valid;
    logic             ready;
    logic [COV_W-1:0] covariance;
    logic             last_out;
    modport source (output valid, output covariance, output last_out, input ready);
    modport sink   (input valid, input covariance, input last_out, output ready);
endinterface

interface gcov_cfg_if;
    import gcov_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/gaussian_covariance.sv -----
// Gaussian covariance model: sill - (sill - nugget) * (1 - exp(-3h^2/range^2)) + nugget.
// Top level; depends on gcov_pkg, the channel interfaces, gcov_div, gcov_exp and gcov_skid.
//
// Usage:
//   i_item carries one lag distance (unsigned Q8.8) and a last flag per item; o_res
//   returns one saturated covariance (unsigned Q9.8, 17 bits) per item, in order,
//   with the last flag copied. i_cfg writes sill (index 0), nugget (index 1) and
//   range (index 2); it is always ready, and other indexes are ignored. Write the
//   registers only while no item is in flight.
//   One item is accepted per cycle while i_item.ready is high. Each item passes 40
//   registers, the first loaded at the edge that accepts it: two for squaring and
//   setup, 21 divider stages (one quotient bit each), 14 exponential stages
//   (series and eight squarings), two for the final scaling and clamp, and the
//   output register.
//   When the receiver stalls, one result waits in the output register and the next
//   in a skid entry; only when the skid entry is full does i_item.ready fall and the
//   whole pipeline hold. Nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and sets sill = 1.0, nugget = 0 and
//   range = 1.0.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_covariance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcov_cfg_if.sink    i_cfg,
    gcov_in_if.sink     i_item,
    gcov_out_if.source  o_res
);
    import gcov_pkg::*;

    logic [CFG_W-1:0] r_sill;
    logic [CFG_W-1:0] r_nugget;
    logic [CFG_W-1:0] r_range;
    logic [R2_W-1:0]  r_r2;

    logic             en;
    logic [CFG_W-1:0] range_eff;

    t_side            r_side_s1;
    logic [H2_W-1:0]  r_h2_s1;
    t_side            r_side_s2;
    logic [NUM_W-1:0] r_num_s2;

    logic [H3_W-1:0]  h2x3;
    t_side            side_s2;
    logic [NUM_W-1:0] num;

    t_side            div_side;
    logic [Q_W-1:0]   div_quot;
    t_side            exp_side;
    logic [E_W-1:0]   exp_e;

    logic [E_W-1:0]   e_rnd;
    logic [F_W-1:0]   fac;
    logic             p_neg;
    logic [CFG_W-1:0] p_mag;
    logic [32:0]      prod;
    t_side            r_side_f1;
    logic [32:0]      r_prod_f1;
    logic             r_neg_f1;

    logic [32:0]      m_full;
    logic [16:0]      m_val;
    logic [16:0]      level_sum;
    logic [17:0]      up;
    logic [COV_W-1:0] cov;
    t_side            r_side_f2;
    logic [COV_W-1:0] r_cov_f2;
    t_res             res;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sill   <= SILL_RST;
            r_nugget <= NUGGET_RST;
            r_range  <= RANGE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SILL:   r_sill   <= i_cfg.data;
                REG_NUGGET: r_nugget <= i_cfg.data;
                REG_RANGE:  r_range  <= i_cfg.data;
                default:    ;
            endcase
        end
    end

    // A zero range is taken as the smallest nonzero range; its square follows the register.
    assign range_eff = (r_range == '0) ? CFG_W'(1) : r_range;

    always_ff @(posedge i_clk) begin
        r_r2 <= {16'b0, range_eff} * {16'b0, range_eff};
    end

    // Every stage moves together while the skid entry has room.
    assign i_item.ready = en;

    // Stage 1: square the lag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_s1 <= '0;
        end else if (en) begin
            r_side_s1 <= '{valid: i_item.valid, last: i_item.last_in, zero: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h2_s1 <= {16'b0, i_item.lag_distance} * {16'b0, i_item.lag_distance};
        end
    end

    // Stage 2: triple it, test for the large argument and form the rounded dividend.
    always_comb begin
        h2x3         = {1'b0, r_h2_s1, 1'b0} + H3_W'(r_h2_s1);
        side_s2      = r_side_s1;
        side_s2.zero = ({2'b0, h2x3} >= {r_r2, 4'b0});
        num          = {1'b0, h2x3, 16'b0} + NUM_W'(r_r2[R2_W-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_s2 <= '0;
        end else if (en) begin
            r_side_s2 <= side_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_s2 <= num;
        end
    end

    gcov_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_side_s2),
        .i_num   (r_num_s2),
        .i_den   (r_r2),
        .o_side  (div_side),
        .o_quot  (div_quot)
    );

    gcov_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (div_side),
        .i_t     (div_quot),
        .o_side  (exp_side),
        .o_e     (exp_e)
    );

    // Final stage 1: round the exponential to Q16, form the factor and scale |sill - nugget|.
    always_comb begin
        e_rnd = exp_e + (E_W'(1) << 13);
        fac   = exp_side.zero ? F_ONE : F_ONE - e_rnd[E_W-1:14];
        p_neg = (r_nugget > r_sill);
        p_mag = p_neg ? r_nugget - r_sill : r_sill - r_nugget;
        prod  = {17'b0, p_mag} * {16'b0, fac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_f1 <= '0;
        end else if (en) begin
            r_side_f1 <= exp_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod_f1 <= prod;
            r_neg_f1  <= p_neg;
        end
    end

    // Final stage 2: round the term half away from zero, apply it and saturate.
    always_comb begin
        m_full    = r_prod_f1 + 33'd32768;
        m_val     = m_full[32:16];
        level_sum = {1'b0, r_sill} + {1'b0, r_nugget};
        up        = {1'b0, level_sum} + {1'b0, m_val};
        if (r_neg_f1) begin
            cov = (up > {1'b0, COV_MAX}) ? COV_MAX : up[COV_W-1:0];
        end else begin
            cov = (m_val > level_sum) ? '0 : level_sum - m_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_f2 <= '0;
        end else if (en) begin
            r_side_f2 <= r_side_f1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cov_f2 <= cov;
        end
    end

    assign res = '{covariance: r_cov_f2, last_out: r_side_f2.last};

    gcov_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_side_f2.valid),
        .i_res   (res),
        .o_ready (en),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ----- rtl/gcov_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, giving t = num / den.
// Depends on gcov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcov_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  gcov_pkg::t_side            i_side,
    input  logic [gcov_pkg::NUM_W-1:0] i_num,
    input  logic [gcov_pkg::R2_W-1:0]  i_den,
    output gcov_pkg::t_side            o_side,
    output logic [gcov_pkg::Q_W-1:0]   o_quot
);
    import gcov_pkg::*;

    logic [R2_W-1:0] rem_in  [Q_W];
    logic [Q_W-1:0]  low_in  [Q_W];
    logic [Q_W-1:0]  quo_in  [Q_W];
    t_side           side_in [Q_W];

    logic [R2_W-1:0] r_rem  [Q_W];
    logic [Q_W-1:0]  r_low  [Q_W];
    logic [Q_W-1:0]  r_quo  [Q_W];
    t_side           r_side [Q_W];

    // The top bits of the dividend form the starting remainder.
    assign rem_in[0]  = R2_W'(i_num[NUM_W-1:Q_W]);
    assign low_in[0]  = i_num[Q_W-1:0];
    assign quo_in[0]  = '0;
    assign side_in[0] = i_side;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [R2_W:0]   trial;
        logic [R2_W:0]   diff;
        logic            ge;
        logic [R2_W-1:0] n_rem;
        logic [Q_W-1:0]  n_quo;

        if (k > 0) begin : g_link
            assign rem_in[k]  = r_rem[k-1];
            assign low_in[k]  = r_low[k-1];
            assign quo_in[k]  = r_quo[k-1];
            assign side_in[k] = r_side[k-1];
        end

        // Shift in the next dividend bit and subtract the divisor if it fits.
        always_comb begin
            trial = {rem_in[k], low_in[k][Q_W-1-k]};
            diff  = trial - {1'b0, i_den};
            ge    = (trial >= {1'b0, i_den});
            n_rem = ge ? diff[R2_W-1:0] : trial[R2_W-1:0];
            n_quo = quo_in[k];
            n_quo[Q_W-1-k] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else if (i_en) begin
                r_side[k] <= side_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= low_in[k];
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_side = r_side[Q_W-1];
    assign o_quot = r_quo[Q_W-1];

endmodule

`default_nettype wire

// ----- rtl/gcov_exp.sv -----
// Pipelined exp(-t) in Q30: a fifth-order series on t/256 followed by eight squarings.
// Depends on gcov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcov_exp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  gcov_pkg::t_side          i_side,
    input  logic [gcov_pkg::Q_W-1:0] i_t,
    output gcov_pkg::t_side          o_side,
    output logic [gcov_pkg::E_W-1:0] o_e
);
    import gcov_pkg::*;

    localparam int Y_W = 26;

    // Stage registers of the series.
    t_side            r_side_s1, r_side_s2, r_side_s3, r_side_s4, r_side_s5, r_side_s6;
    logic [Y_W-1:0]   r_y_s1, r_y_s2, r_y_s3, r_y_s4;
    logic [21:0]      r_y2_s1, r_y2_s2, r_y2_s3, r_y2_s4;
    logic [17:0]      r_y3_s2;
    logic [13:0]      r_y4_s3;
    logic [9:0]       r_y5_s4;
    logic [15:0]      r_d3_s3, r_d3_s4;
    logic [9:0]       r_d4_s4;
    logic [E_W-1:0]   r_pos_s5;
    logic [Y_W:0]     r_neg_s5;
    logic [E_W-1:0]   r_e_s6;

    // Squaring stages.
    t_side            r_sq_side [SQ_N];
    logic [E_W-1:0]   r_sq      [SQ_N];
    logic [E_W-1:0]   sq_in     [SQ_N];
    t_side            sq_side_in[SQ_N];

    logic [Y_W-1:0]   y;
    t_side            side_s0;
    logic [51:0]      p_y2;
    logic [47:0]      p_y3;
    logic [43:0]      p_y4;
    logic [39:0]      p_y5;
    logic [15:0]      d4;
    logic [3:0]       d5;
    logic [E_W-1:0]   pos;
    logic [Y_W:0]     neg;

    // Arguments of 16.0 and above give an exponential of zero.
    always_comb begin
        y            = {i_t[Q_W-2:0], 6'b0};
        side_s0      = i_side;
        side_s0.zero = i_side.zero | i_t[Q_W-1];
    end

    // Powers of y, one multiplication per stage.
    assign p_y2 = {26'b0, y} * {26'b0, y};
    assign p_y3 = {26'b0, r_y2_s1} * {22'b0, r_y_s1};
    assign p_y4 = {26'b0, r_y3_s2} * {18'b0, r_y_s2};
    assign p_y5 = {26'b0, r_y4_s3} * {14'b0, r_y_s3};

    // The fourth power over 24 is taken as a third of the fourth power over 8.
    assign d4 = div3({6'b0, r_y4_s3[13:3]});

    // Positive and negative halves of the series.
    always_comb begin
        d5  = div15(r_y5_s4[9:3]);
        pos = (E_W'(1) << 30) + E_W'(r_y2_s4[21:1]) + E_W'(r_d4_s4);
        neg = (Y_W+1)'(r_y_s4) + (Y_W+1)'(r_d3_s4) + (Y_W+1)'(d5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_s1 <= '0;
            r_side_s2 <= '0;
            r_side_s3 <= '0;
            r_side_s4 <= '0;
            r_side_s5 <= '0;
            r_side_s6 <= '0;
        end else if (i_en) begin
            r_side_s1 <= side_s0;
            r_side_s2 <= r_side_s1;
            r_side_s3 <= r_side_s2;
            r_side_s4 <= r_side_s3;
            r_side_s5 <= r_side_s4;
            r_side_s6 <= r_side_s5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y_s1   <= y;
            r_y2_s1  <= p_y2[51:30];
            r_y_s2   <= r_y_s1;
            r_y2_s2  <= r_y2_s1;
            r_y3_s2  <= p_y3[47:30];
            r_y_s3   <= r_y_s2;
            r_y2_s3  <= r_y2_s2;
            r_y4_s3  <= p_y4[43:30];
            r_d3_s3  <= div3(r_y3_s2[17:1]);
            r_y_s4   <= r_y_s3;
            r_y2_s4  <= r_y2_s3;
            r_y5_s4  <= p_y5[39:30];
            r_d3_s4  <= r_d3_s3;
            r_d4_s4  <= d4[9:0];
            r_pos_s5 <= pos;
            r_neg_s5 <= neg;
            r_e_s6   <= r_pos_s5 - E_W'(r_neg_s5);
        end
    end

    // Eight rounded squarings raise the series result to the 256th power.
    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        logic [2*E_W-1:0] prod;

        if (k == 0) begin : g_first
            assign sq_in[k]      = r_e_s6;
            assign sq_side_in[k] = r_side_s6;
        end else begin : g_next
            assign sq_in[k]      = r_sq[k-1];
            assign sq_side_in[k] = r_sq_side[k-1];
        end

        assign prod = {31'b0, sq_in[k]} * {31'b0, sq_in[k]} + (62'd1 << 29);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_side[k] <= '0;
            end else if (i_en) begin
                r_sq_side[k] <= sq_side_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k] <= prod[60:30];
            end
        end
    end

    assign o_side = r_sq_side[SQ_N-1];
    assign o_e    = r_sq[SQ_N-1];

endmodule

`default_nettype wire

// ----- rtl/gcov_skid.sv -----
// Output register with a skid entry, so the pipeline keeps moving while one result waits.
// Depends on gcov_pkg and gcov_out_if.
`timescale 1ns / 1ps
`default_nettype none

module gcov_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gcov_pkg::t_res i_res,
    output logic           o_ready,
    gcov_out_if.source     o_res
);
    import gcov_pkg::*;

    logic r_out_v;
    logic r_skid_v;
    t_res r_out;
    t_res r_skid;
    logic take;
    logic push;
    logic load;

    assign o_ready = !r_skid_v;
    assign take    = r_out_v & o_res.ready;
    assign push    = i_valid & !r_skid_v;
    assign load    = !r_out_v | take;

    // Occupancy of the output register and the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (load) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    // The skid entry is drained first, so items leave in order.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_skid_v ? r_skid : i_res;
        end else if (push) begin
            r_skid <= i_res;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.covariance = r_out.covariance;
    assign o_res.last_out   = r_out.last_out;

endmodule

`default_nettype wire

// ----- bench/gcov_checker.sv -----
// Checker for the Gaussian covariance block: watches the three channels and predicts
// every covariance item. Depends on gcov_pkg only.
`timescale 1ns / 1ps

module gcov_checker import gcov_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_item_valid,
    input  logic                 i_item_ready,
    input  logic [LAG_W-1:0]     i_lag_distance,
    input  logic                 i_last_in,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [COV_W-1:0]     i_covariance,
    input  logic                 i_last_out,
    output int                   o_mismatches,
    output int                   o_outstanding,
    output int                   o_checked
);

    // Local copy of the model registers.
    logic [CFG_W-1:0] sill_copy;
    logic [CFG_W-1:0] nugget_copy;
    logic [CFG_W-1:0] range_copy;

    // Covariance items predicted but not yet seen on the output.
    t_res cov_expect_q[$];

    // Gaussian covariance in fixed point: the exponential comes from a fifth-order
    // series over t/256, squared eight times, then rounded to Q16.
    function automatic t_res predict_covariance(input logic [LAG_W-1:0] lag,
                                                input logic             last,
                                                input logic [CFG_W-1:0] sill,
                                                input logic [CFG_W-1:0] nugget,
                                                input logic [CFG_W-1:0] rng);
        logic [63:0] h, r, h2x3, r2, t, y, y2, y3, y4, y5, e, e16, fac, mag, m;
        longint      p, term, cov;
        t_res        res;
        h    = {48'b0, lag};
        r    = (rng == '0) ? 64'd1 : {48'b0, rng};
        h2x3 = 64'd3 * h * h;
        r2   = r * r;
        e16  = 64'd0;
        // Beyond the cut-off the exponential is taken as zero.
        if (h2x3 < 64'd16 * r2) begin
            t = ((h2x3 << 16) + r2 / 64'd2) / r2;
            if (t < (64'd16 << 16)) begin
                y  = t << 6;
                y2 = (y * y) >> 30;
                y3 = (y2 * y) >> 30;
                y4 = (y3 * y) >> 30;
                y5 = (y4 * y) >> 30;
                e  = 64'd1 << 30;
                e  = e - y;
                e  = e + y2 / 64'd2;
                e  = e - y3 / 64'd6;
                e  = e + y4 / 64'd24;
                e  = e - y5 / 64'd120;
                for (int i = 0; i < 8; i++) begin
                    e = (e * e + (64'd1 << 29)) >> 30;
                end
                e16 = (e + (64'd1 << 13)) >> 14;
            end
        end
        fac = 64'd65536 - e16;
        // The scaled term rounds half away from zero and keeps the sign of sill - nugget.
        p    = longint'(sill) - longint'(nugget);
        mag  = (p < 0) ? 64'(-p) : 64'(p);
        m    = (mag * fac + 64'd32768) >> 16;
        term = (p < 0) ? -longint'(m) : longint'(m);
        cov  = longint'(sill) + longint'(nugget) - term;
        if (cov < 0) begin
            cov = 0;
        end
        if (cov > longint'(COV_MAX)) begin
            cov = longint'(COV_MAX);
        end
        res.covariance = cov[COV_W-1:0];
        res.last_out   = last;
        return res;
    endfunction

    // Compare results, queue predictions and follow register writes at each edge.
    always @(posedge i_clk) begin : watch
        t_res want;
        int   bad;
        int   seen;
        bad  = 0;
        seen = 0;
        if (!i_rst_n) begin
            sill_copy     <= SILL_RST;
            nugget_copy   <= NUGGET_RST;
            range_copy    <= RANGE_RST;
            cov_expect_q.delete();
            o_mismatches  <= 0;
            o_outstanding <= 0;
            o_checked     <= 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (cov_expect_q.size() == 0) begin
                    $display("%0t: covariance item with none expected, actual %0d last %0b",
                             $time, i_covariance, i_last_out);
                    bad++;
                end else begin
                    want = cov_expect_q.pop_front();
                    seen = 1;
                    if (i_covariance !== want.covariance) begin
                        $display("%0t: covariance mismatch, expected %0d, actual %0d",
                                 $time, want.covariance, i_covariance);
                        bad++;
                    end
                    if (i_last_out !== want.last_out) begin
                        $display("%0t: last flag mismatch, expected %0b, actual %0b",
                                 $time, want.last_out, i_last_out);
                        bad++;
                    end
                end
            end
            if (i_item_valid && i_item_ready) begin
                cov_expect_q.push_back(predict_covariance(i_lag_distance, i_last_in,
                                                          sill_copy, nugget_copy,
                                                          range_copy));
            end
            // Writes to an unused index change nothing.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SILL: begin
                        sill_copy <= i_cfg_data;
                    end
                    REG_NUGGET: begin
                        nugget_copy <= i_cfg_data;
                    end
                    REG_RANGE: begin
                        range_copy <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            o_mismatches  <= o_mismatches + bad;
            o_checked     <= o_checked + seen;
            o_outstanding <= cov_expect_q.size();
        end
    end

endmodule

// ----- bench/gaussian_covariance_test.sv -----
// Top of the Gaussian covariance testbench: clock, reset, stimulus and verdict.
// Depends on gcov_pkg, the channel interfaces, the block itself and gcov_checker.
`timescale 1ns / 1ps

module gaussian_covariance_test;
    import gcov_pkg::*;

    // Index with no register behind it; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    bit   tx_calm;
    bit   rx_calm;
    int   rx_hold;
    int   lags_sent;
    int   settings_used;
    int   mismatches;
    int   outstanding;
    int   checked;

    gcov_cfg_if cfg_ch ();
    gcov_in_if  item_ch ();
    gcov_out_if res_ch ();

    gaussian_covariance uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_item  (item_ch),
        .o_res   (res_ch)
    );

    gcov_checker watcher (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_ch.valid),
        .i_cfg_ready    (cfg_ch.ready),
        .i_cfg_index    (cfg_ch.index),
        .i_cfg_data     (cfg_ch.data),
        .i_item_valid   (item_ch.valid),
        .i_item_ready   (item_ch.ready),
        .i_lag_distance (item_ch.lag_distance),
        .i_last_in      (item_ch.last_in),
        .i_res_valid    (res_ch.valid),
        .i_res_ready    (res_ch.ready),
        .i_covariance   (res_ch.covariance),
        .i_last_out     (res_ch.last_out),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    always #4 clk = ~clk;

    // Result side: after each accepted item, hold ready low for a random number of cycles.
    always @(posedge clk) begin : result_sink
        int hold;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            rx_hold      <= 0;
        end else if (res_ch.valid && res_ch.ready) begin
            hold = rx_calm ? 0 : $urandom_range(0, 8);
            res_ch.ready <= (hold == 0);
            rx_hold      <= (hold == 0) ? 0 : hold - 1;
        end else if (!res_ch.ready) begin
            if (rx_hold == 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                rx_hold <= rx_hold - 1;
            end
        end
    end

    // Offer one lag item after a random gap and wait until it is taken.
    task automatic send_lag(input logic [LAG_W-1:0] lag, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.lag_distance <= lag;
        item_ch.last_in      <= last;
        do @(posedge clk); while (!item_ch.ready);
        lags_sent++;
    endtask

    // Stop sending and wait until every predicted item has come back.
    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // One register write; valid stays high so back-to-back writes need no toggle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            cfg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Load a new model once the pipeline is empty.
    task automatic set_model(input logic [CFG_W-1:0] sill, input logic [CFG_W-1:0] nugget,
                             input logic [CFG_W-1:0] rng);
        drain();
        write_reg(REG_SILL, sill);
        write_reg(REG_NUGGET, nugget);
        write_reg(REG_RANGE, rng);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Run time limit, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_W-1:0] sill, nugget, rng, swap;
        logic [LAG_W-1:0] lag;
        int               array_left;
        int               reach;
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.lag_distance = '0;
        item_ch.last_in      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_SILL;
        cfg_ch.data          = '0;
        tx_calm              = 1'b0;
        rx_calm              = 1'b0;
        lags_sent            = 0;
        settings_used        = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset model: zero lag, one range, either side of the large-argument cut-off, top.
        send_lag(16'h0000, 1'b0);
        send_lag(16'h0001, 1'b0);
        send_lag(16'h0100, 1'b1);
        send_lag(16'd591, 1'b0);
        send_lag(16'd592, 1'b0);
        send_lag(16'hFFFF, 1'b1);

        // Zero range behaves as the smallest range, with a full-scale sill.
        set_model(16'hFFFF, 16'h0000, 16'h0000);
        send_lag(16'h0000, 1'b0);
        send_lag(16'h0001, 1'b0);
        send_lag(16'hFFFF, 1'b1);

        // Nugget above sill, with the widest range.
        set_model(16'h0000, 16'hFFFF, 16'hFFFF);
        send_lag(16'h0000, 1'b1);
        send_lag(16'h7FFF, 1'b0);
        send_lag(16'hAAAA, 1'b0);
        send_lag(16'h5555, 1'b0);
        send_lag(16'hFFFF, 1'b1);

        // Sill and nugget both at full scale, range at its smallest.
        set_model(16'hFFFF, 16'hFFFF, 16'h0001);
        send_lag(16'h0000, 1'b0);
        send_lag(16'h0001, 1'b1);

        // A write to the unused index must leave the model untouched.
        drain();
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_ch.valid <= 1'b0;
        send_lag(16'($urandom), 1'b0);
        send_lag(16'($urandom_range(0, 4)), 1'b1);

        // Random phases: each loads a fresh model and sends arrays of lags, most of them
        // inside the range where the exponential is still live.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: rng = 16'($urandom_range(1, 64));
                1: rng = 16'($urandom_range(64, 1024));
                2: rng = 16'($urandom_range(1024, 65535));
                3: rng = (ph == 3) ? 16'h0000 : 16'hFFFF;
                default: rng = 16'($urandom_range(1, 4096));
            endcase
            sill   = 16'($urandom);
            nugget = 16'($urandom);
            if (ph % 2 == 0 && nugget > sill) begin
                swap   = sill;
                sill   = nugget;
                nugget = swap;
            end
            tx_calm = (ph == 1 || ph == 6);
            rx_calm = (ph == 1 || ph == 4);
            set_model(sill, nugget, rng);
            reach = (rng == '0) ? 3 : 3 * int'(rng);
            if (reach > 65535) begin
                reach = 65535;
            end
            array_left = 0;
            for (int k = 0; k < 40; k++) begin
                if (array_left == 0) begin
                    array_left = $urandom_range(1, 12);
                end
                lag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, reach));
                send_lag(lag, array_left == 1);
                array_left--;
                // Let the pipeline run dry once in the middle of a phase.
                if (ph == 5 && k == 20) begin
                    drain();
                end
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        drain();
        repeat (60) @(posedge clk);
        $display("Sent %0d lag items over %0d register settings; %0d covariance items checked.",
                 lags_sent, settings_used, checked);
        $display("Settings covered zero and full-scale range, nugget above sill and the cut-off.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
